>>> rtl/core/prt_pkg.sv
// Shared types and constants for the pending request tracker.
package prt_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam logic [15:0] TIMEOUT_RESET_S = 16'd10;

    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_REPLY = 2'd1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_MATCHED   = 3'd2;
    localparam logic [2:0] ST_UNMATCHED = 3'd3;
    localparam logic [2:0] ST_TICK      = 3'd4;
    localparam logic [2:0] ST_SHORT     = 3'd5;

    // Classified operation handed from front to back.
    typedef enum logic [3:0] {
        K_QUERY = 4'b0001,
        K_REPLY = 4'b0010,
        K_TICK  = 4'b0100,
        K_SHORT = 4'b1000
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] id;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] now;
    } t_job;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ip;
        logic [15:0] port;
        logic [6:0]  evicted;
    } t_res;
endpackage

>>> rtl/core/prt_front.sv
// Front end: classifies incoming beats and queues them for the table engine.
module prt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [1:0]       i_operation,
    input  logic [15:0]      i_transaction_id,
    input  logic [9:0]       i_packet_length,
    input  logic [31:0]      i_client_ip,
    input  logic [15:0]      i_client_port,
    input  logic [31:0]      i_now_seconds,
    output logic             o_job_valid,
    output prt_pkg::t_job    o_job,
    input  logic             i_job_take
);
    import prt_pkg::*;

    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job n_job;
    logic wr, rd;

    // Classify the operation
    always_comb begin
        n_job.id   = i_transaction_id;
        n_job.ip   = i_client_ip;
        n_job.port = i_client_port;
        n_job.now  = i_now_seconds;
        if (i_operation == OP_QUERY || i_operation == OP_REPLY) begin
            if (i_packet_length < 10'd2) n_job.kind = K_SHORT;
            else if (i_operation == OP_QUERY) n_job.kind = K_QUERY;
            else n_job.kind = K_REPLY;
        end else begin
            n_job.kind = K_TICK;
        end
    end

    assign o_full      = r_cnt[1];
    assign wr          = i_push && !o_full;
    assign o_job_valid = r_cnt != 2'd0;
    assign rd          = i_job_take && o_job_valid;
    assign o_job       = r_q[r_rp];

    // Two-entry queue
    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= n_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

>>> rtl/core/prt_back.sv
// Back end: scans the table for insert, match and timeout, one entry a cycle.
module prt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_job_valid,
    input  prt_pkg::t_job  i_job,
    output logic           o_job_take,
    output logic           o_res_valid,
    output prt_pkg::t_res  o_res,
    input  logic           i_res_take
);
    import prt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DONE  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] time_s;
        logic [31:0] order;
    } t_entry;

    // Valid bits in flops, entry payload in a memory with registered read
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry      r_mem [TABLE_ENTRIES];
    t_entry      r_rd;
    logic [IDX_W-1:0] r_rd_idx;

    t_state      r_state;
    t_job        r_job;
    logic [15:0] r_timeout;
    logic [31:0] r_seq;
    logic [CNT_W-1:0] r_idx;
    logic        r_found;
    logic [IDX_W-1:0] r_best;
    logic [31:0] r_best_age;
    logic [31:0] r_best_ip;
    logic [15:0] r_best_port;
    logic [6:0]  r_evict;
    logic [2:0]  r_status;
    logic [31:0] r_mip;
    logic [15:0] r_mport;
    logic        r_out_v;
    t_res        r_out;

    logic [IDX_W-1:0] idx;
    logic [31:0] age, stale_age;
    logic last, scan_end, rd_ok, hit, stale, mem_we, emit;
    t_entry wr_entry;

    // r_rd holds entry r_idx-1 while r_idx is nonzero
    assign idx        = r_idx[IDX_W-1:0];
    assign last       = r_idx == CNT_W'(TABLE_ENTRIES - 1);
    assign scan_end   = r_idx == CNT_W'(TABLE_ENTRIES);
    assign rd_ok      = r_idx != '0;
    assign age        = r_seq - r_rd.order;
    assign hit        = rd_ok && r_valid[r_rd_idx] && r_rd.id == r_job.id;
    assign stale_age  = r_job.now - r_rd.time_s;
    assign stale      = rd_ok && r_valid[r_rd_idx] && stale_age > {16'd0, r_timeout};
    assign mem_we     = r_state == S_SCAN && r_job.kind == K_QUERY && !r_valid[idx];
    assign emit       = r_state == S_OUT && (!r_out_v || i_res_take);
    assign wr_entry   = '{id: r_job.id, ip: r_job.ip, port: r_job.port,
                          time_s: r_job.now, order: r_seq};
    assign o_job_take = r_state == S_IDLE && i_job_valid;
    assign o_res_valid = r_out_v;
    assign o_res      = r_out;

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[idx] <= wr_entry;
        r_rd     <= r_mem[idx];
        r_rd_idx <= idx;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.status  <= r_status;
            r_out.ip      <= r_mip;
            r_out.port    <= r_mport;
            r_out.evicted <= r_evict;
        end
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (emit) r_out_v <= 1'b1;
        else if (i_res_take) r_out_v <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_timeout <= TIMEOUT_RESET_S;
            r_seq     <= '0;
        end else begin
            if (i_cfg_we) r_timeout <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_evict <= '0;
                        r_mip   <= '0;
                        r_mport <= '0;
                        unique case (i_job.kind)
                            K_QUERY: begin
                                r_status <= ST_FULL;
                                r_state  <= S_SCAN;
                            end
                            K_REPLY: begin
                                r_status <= ST_UNMATCHED;
                                r_state  <= S_SCAN;
                            end
                            K_SHORT: begin
                                r_status <= ST_SHORT;
                                r_state  <= S_SWEEP;
                            end
                            default: begin
                                r_status <= ST_TICK;
                                r_state  <= S_SWEEP;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Query: first free slot ends the scan
                    if (r_job.kind == K_QUERY) begin
                        if (!r_valid[idx]) begin
                            r_valid[idx] <= 1'b1;
                            r_seq        <= r_seq + 32'd1;
                            r_status     <= ST_INSERTED;
                            r_idx        <= '0;
                            r_state      <= S_SWEEP;
                        end else if (last) begin
                            r_idx   <= '0;
                            r_state <= S_SWEEP;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        // Reply: keep newest matching entry
                        if (hit && (!r_found || age < r_best_age)) begin
                            r_found     <= 1'b1;
                            r_best      <= r_rd_idx;
                            r_best_age  <= age;
                            r_best_ip   <= r_rd.ip;
                            r_best_port <= r_rd.port;
                        end
                        if (scan_end) begin
                            r_idx   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    // Free matched entry before the timeout sweep
                    if (r_found) begin
                        r_valid[r_best] <= 1'b0;
                        r_status        <= ST_MATCHED;
                        r_mip           <= r_best_ip;
                        r_mport         <= r_best_port;
                    end
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (stale) begin
                        r_valid[r_rd_idx] <= 1'b0;
                        r_evict           <= r_evict + 7'd1;
                    end
                    if (scan_end) r_state <= S_OUT;
                    else r_idx <= r_idx + 1'b1;
                end
                S_OUT: begin
                    // Wait for the output register to free up
                    if (emit) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/pending_request_tracker.sv
// Top level of the pending request tracker.
// Tracks up to 64 outstanding requests by 16-bit transaction id. Each beat is
// queued by a two-entry front queue, then the table engine walks the table one
// entry per cycle, reading entry data from memory in the cycle after the
// address: a query probes valid bits for the first free slot, a reply reads
// all 64 entries for the newest match and then frees it in a separate step,
// and every beat then sweeps all 64 entries for timeout. The engine takes a
// new item only when idle, after the last result goes to the output register.
// One result beat per input beat, held in an output register so the next item
// can start while it waits.
module pending_request_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_transaction_id,
    input  logic [9:0]  i_packet_length,
    input  logic [31:0] i_client_ip,
    input  logic [15:0] i_client_port,
    input  logic [31:0] i_now_seconds,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [31:0] o_match_ip,
    output logic [15:0] o_match_port,
    output logic [6:0]  o_evicted_count,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import prt_pkg::*;

    t_job job;
    t_res res;
    logic job_valid, job_take, res_valid;

    prt_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_operation, .i_transaction_id, .i_packet_length,
        .i_client_ip, .i_client_port, .i_now_seconds,
        .o_job_valid(job_valid), .o_job(job), .i_job_take(job_take)
    );

    prt_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_job_valid(job_valid), .i_job(job), .o_job_take(job_take),
        .o_res_valid(res_valid), .o_res(res), .i_res_take(pop)
    );

    assign empty           = !res_valid;
    assign o_status        = res.status;
    assign o_match_ip      = res.ip;
    assign o_match_port    = res.port;
    assign o_evicted_count = res.evicted;
endmodule

>>> tb/prt_checker.sv
// Checker for the pending request tracker: predicts each result beat and compares.
`timescale 1ns / 100ps
module prt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_transaction_id,
    input  logic [9:0]  i_packet_length,
    input  logic [31:0] i_client_ip,
    input  logic [15:0] i_client_port,
    input  logic [31:0] i_now_seconds,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_match_ip,
    input  logic [15:0] i_match_port,
    input  logic [6:0]  i_evicted_count,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import prt_pkg::*;

    // Shadow copy of the request table
    logic [15:0] timeout_s;
    logic        slot_live  [TABLE_ENTRIES];
    logic [15:0] slot_id    [TABLE_ENTRIES];
    logic [31:0] slot_ip    [TABLE_ENTRIES];
    logic [15:0] slot_port  [TABLE_ENTRIES];
    logic [31:0] slot_time  [TABLE_ENTRIES];
    logic [31:0] slot_seq   [TABLE_ENTRIES];
    logic [31:0] next_seq;
    t_res        expected_beats[$];

    assign o_pending = expected_beats.size();

    // Apply one request to the shadow table and return its result
    function automatic t_res track_request(logic [1:0] op, logic [15:0] id, logic [9:0] len,
                                           logic [31:0] ip, logic [15:0] port,
                                           logic [31:0] now);
        t_res        r;
        logic        found;
        int          best;
        logic [31:0] best_age;
        logic [31:0] age;
        int          cnt;
        r = '0;
        r.status = ST_TICK;
        found = 1'b0;
        best = 0;
        best_age = '0;
        cnt = 0;
        if (op == OP_QUERY || op == OP_REPLY) begin
            if (len < 2) begin
                r.status = ST_SHORT;
            end else if (op == OP_QUERY) begin
                r.status = ST_FULL;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (!slot_live[i]) begin
                        slot_live[i] = 1'b1;
                        slot_id[i] = id;
                        slot_ip[i] = ip;
                        slot_port[i] = port;
                        slot_time[i] = now;
                        slot_seq[i] = next_seq;
                        next_seq = next_seq + 1;
                        r.status = ST_INSERTED;
                        break;
                    end
                end
            end else begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (slot_live[i] && slot_id[i] == id) begin
                        age = next_seq - slot_seq[i];
                        if (!found || age < best_age) begin
                            found = 1'b1;
                            best = i;
                            best_age = age;
                        end
                    end
                end
                if (found) begin
                    r.status = ST_MATCHED;
                    r.ip = slot_ip[best];
                    r.port = slot_port[best];
                    slot_live[best] = 1'b0;
                end else begin
                    r.status = ST_UNMATCHED;
                end
            end
        end
        // Timeout sweep, wrap-safe age
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            age = now - slot_time[i];
            if (slot_live[i] && age > {16'd0, timeout_s}) begin
                slot_live[i] = 1'b0;
                cnt++;
            end
        end
        r.evicted = (cnt > 127) ? 7'd127 : cnt[6:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res got;
        t_res exp_r;
        if (!i_rst_n) begin
            timeout_s <= TIMEOUT_RESET_S;
            next_seq = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) slot_live[i] = 1'b0;
            expected_beats.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) timeout_s <= i_cfg_data;
            if (push && !full)
                expected_beats.push_back(track_request(i_operation, i_transaction_id,
                    i_packet_length, i_client_ip, i_client_port, i_now_seconds));
            if (pop && !empty) begin
                got.status = i_status;
                got.ip = i_match_ip;
                got.port = i_match_port;
                got.evicted = i_evicted_count;
                if (expected_beats.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result beat %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_beats.pop_front();
                    if (got !== exp_r) begin
                        if (o_errors < 10)
                            $display("mismatch: exp st=%0d ip=%h port=%h ev=%0d, got st=%0d ip=%h port=%h ev=%0d",
                                exp_r.status, exp_r.ip, exp_r.port, exp_r.evicted,
                                got.status, got.ip, got.port, got.evicted);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the pending request tracker testbench.
`timescale 1ns / 100ps
module tb_top;
    import prt_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  op_d = '0;
    logic [15:0] id_d = '0;
    logic [9:0]  len_d = '0;
    logic [31:0] ip_d = '0;
    logic [15:0] port_d = '0;
    logic [31:0] now_d = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  status;
    logic [31:0] match_ip;
    logic [15:0] match_port;
    logic [6:0]  evicted;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    logic        hold_off = 1'b0;
    logic [31:0] clock_s = 32'd100;
    logic [15:0] id_pool[8];

    always #5 i_clk = ~i_clk;

    pending_request_tracker i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_operation(op_d), .i_transaction_id(id_d), .i_packet_length(len_d),
        .i_client_ip(ip_d), .i_client_port(port_d), .i_now_seconds(now_d),
        .empty(empty), .pop(pop), .o_status(status), .o_match_ip(match_ip),
        .o_match_port(match_port), .o_evicted_count(evicted),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    prt_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_operation(op_d), .i_transaction_id(id_d), .i_packet_length(len_d),
        .i_client_ip(ip_d), .i_client_port(port_d), .i_now_seconds(now_d),
        .empty(empty), .pop(pop), .i_status(status), .i_match_ip(match_ip),
        .i_match_port(match_port), .i_evicted_count(evicted),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: random stall pattern, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) pop <= 1'b0;
        else pop <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request beat and wait for acceptance
    task automatic send_request(logic [1:0] op, logic [15:0] id, logic [9:0] len,
                                logic [31:0] ip, logic [15:0] port, logic [31:0] now);
        push <= 1'b1;
        op_d <= op;
        id_d <= id;
        len_d <= len;
        ip_d <= ip;
        port_d <= port;
        now_d <= now;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic pause_sender();
        push <= 1'b0;
    endtask

    // Drain all results, let the engine settle, then write the timeout
    task automatic set_timeout(logic [15:0] value);
        pause_sender();
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Random beat: mostly queries and replies on a small id pool
    task automatic random_request();
        int          sel;
        logic [1:0]  op;
        logic [15:0] id;
        logic [9:0]  len;
        sel = $urandom_range(0, 99);
        if (sel < 45) op = OP_QUERY;
        else if (sel < 85) op = OP_REPLY;
        else if (sel < 95) op = OP_TICK;
        else op = OP_SPARE;
        id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
        len = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(0, 1))
                                           : 10'($urandom_range(2, 1023));
        clock_s = clock_s + $urandom_range(0, 3);
        if ($urandom_range(0, 99) == 0) clock_s = $urandom;
        send_request(op, id, len, $urandom, 16'($urandom), clock_s);
    endtask

    task automatic random_phase(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++) begin
                random_request();
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                pause_sender();
                repeat ($urandom_range(1, 200)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < 8; k++) id_pool[k] = 16'($urandom);
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every operation, short packets, duplicates
        send_request(OP_QUERY, 16'h0000, 10'd2, 32'hFFFFFFFF, 16'hFFFF, 32'd0);
        send_request(OP_QUERY, 16'hFFFF, 10'd1023, 32'h0, 16'h0, 32'd1);
        send_request(OP_QUERY, 16'h1234, 10'd512, 32'hA5A5A5A5, 16'h5A5A, 32'd2);
        send_request(OP_QUERY, 16'h1234, 10'd100, 32'h5A5A5A5A, 16'hA5A5, 32'd3);
        send_request(OP_REPLY, 16'h1234, 10'd2, 32'h0, 16'h0, 32'd4);
        send_request(OP_REPLY, 16'h1234, 10'd2, 32'h0, 16'h0, 32'd4);
        send_request(OP_REPLY, 16'h1234, 10'd2, 32'h0, 16'h0, 32'd5);
        send_request(OP_QUERY, 16'h7777, 10'd0, 32'h1, 16'h1, 32'd5);
        send_request(OP_REPLY, 16'h0000, 10'd1, 32'h1, 16'h1, 32'd5);
        send_request(OP_TICK, 16'hFFFF, 10'd0, 32'hFFFFFFFF, 16'hFFFF, 32'd6);
        send_request(OP_SPARE, 16'h0, 10'd0, 32'h0, 16'h0, 32'd7);
        send_request(OP_REPLY, 16'hFFFF, 10'd3, 32'h0, 16'h0, 32'd10);
        send_request(OP_TICK, 16'h0, 10'd5, 32'h0, 16'h0, 32'd11);
        // Future timestamp then wrap of the clock
        send_request(OP_QUERY, 16'h4321, 10'd9, 32'hDEADBEEF, 16'h0035, 32'hFFFFFFFF);
        send_request(OP_TICK, 16'h0, 10'd0, 32'h0, 16'h0, 32'd5);
        send_request(OP_TICK, 16'h0, 10'd0, 32'h0, 16'h0, 32'hFFFFFFF0);
        // Fill the table past full, then evict everything at once
        for (int k = 0; k < 66; k++)
            send_request(OP_QUERY, 16'(k), 10'd20, 32'(k * 7), 16'(k), 32'd1000);
        send_request(OP_TICK, 16'h0, 10'd0, 32'h0, 16'h0, 32'd2000);

        // Random phases under several timeouts, extremes among them
        set_timeout(16'd0);
        clock_s = 32'd500;
        random_phase(150);
        set_timeout(16'hFFFF);
        random_phase(250);
        set_timeout(16'd30);
        // Long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (6000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(40);
        join
        random_phase(300);
        set_timeout(16'd3);
        random_phase(250);
        set_timeout(TIMEOUT_RESET_S);
        random_phase(200);
        pause_sender();

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
